>>> rtl/core/utc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg
// types, codes and helpers shared by the text console cursor modules
// ----------------------------------------------------------------------------
package utc_pkg;

   // register reset values
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET    = 8'd25;
   localparam logic [3:0] COLOR_RESET   = 4'd0;

   // geometry floors
   localparam logic [8:0] MIN_COLUMNS = 9'd2;
   localparam logic [8:0] MIN_ROWS    = 9'd1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int MAX_CMDS   = 3;

   // register index
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COLUMNS    = 2'd0,
      CSR_ROWS       = 2'd1,
      CSR_FORE_COLOR = 2'd2,
      CSR_BACK_COLOR = 2'd3
   } utc_csr_type;

   // command kind
   typedef enum logic [1:0] {
      OP_NARROW = 2'd0,
      OP_WIDE   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_SCROLL = 2'd3
   } utc_op_type;

   typedef struct packed {
      utc_op_type  op;
      logic [15:0] glyph_code;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [3:0]  fg;
      logic [3:0]  bg;
   } utc_cmd_type;

   // commands caused by one byte, oldest in slot 0
   typedef struct packed {
      utc_cmd_type [MAX_CMDS-1:0] cmd;
      logic [1:0]                 count;
   } utc_batch_type;

   typedef struct packed {
      logic [7:0] columns;
      logic [7:0] rows;
      logic [3:0] fore_color;
      logic [3:0] back_color;
   } utc_cfg_type;

   typedef struct packed {
      logic [1:0]  pending;
      logic [15:0] partial;
      logic [7:0]  col;
      logic [7:0]  row;
   } utc_state_type;

   function automatic utc_cmd_type make_cmd(
      input utc_op_type  op,
      input logic [15:0] glyph,
      input logic [7:0]  col,
      input logic [7:0]  row,
      input logic [3:0]  fg,
      input logic [3:0]  bg
   );
      utc_cmd_type c;
      c.op         = op;
      c.glyph_code = glyph;
      c.cell_col   = col;
      c.cell_row   = row;
      c.fg         = fg;
      c.bg         = bg;
      return c;
   endfunction

endpackage

>>> rtl/core/utf8_text_console_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_console_cursor
// utf-8 text byte stream to draw, clear and scroll commands for a cell console
// ----------------------------------------------------------------------------
// path: a byte taken goes into the input register and moves on to the result
//   register once that can hold all of its words; its first command word is
//   then offered from the result register
// throughput: one byte per cycle while each byte gives at most one word and
//   rsp_tready is high; a byte with more words holds the input register while they drain
// reset: synchronous, clears the decode state, the cursor and both valid flags;
//   geometry returns to 80 columns by 25 rows, both colors to 0
// ----------------------------------------------------------------------------
module utf8_text_console_cursor (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [utc_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [utc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // text bytes
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [utc_pkg::REQ_DATA_W-1:0]        req_tdata,  // in_byte
   // command words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [1:0]                            rsp_tuser,  // op
   output logic [utc_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // glyph_code, cell_col,
                                                             // cell_row, fg, bg
   output logic                                  rsp_tlast
);

   // input register
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;

   // decoder and cursor state
   utc_pkg::utc_state_type st_ff;
   utc_pkg::utc_state_type st_in;

   // geometry and colors
   utc_pkg::utc_cfg_type   cfg_ff;

   utc_pkg::utc_batch_type batch;
   logic                   q_free;
   logic                   in_take;

   // the byte in the input register moves on once the result register can hold
   // all of its words; an empty or last-word-leaving result register counts
   assign in_take    = in_valid_ff && q_free;
   assign req_tready = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // one pass of decode, cursor move, wrap and scroll
   utc_step u_step (
      .byte_i  (in_byte_ff),
      .state_i (st_ff),
      .cfg_i   (cfg_ff),
      .state_o (st_in),
      .batch_o (batch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (in_take) begin
         st_ff <= st_in;
      end
   end

   // register writes; a pending sequence is left alone
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns    <= utc_pkg::COLUMNS_RESET;
         cfg_ff.rows       <= utc_pkg::ROWS_RESET;
         cfg_ff.fore_color <= utc_pkg::COLOR_RESET;
         cfg_ff.back_color <= utc_pkg::COLOR_RESET;
      end else if (csr_we) begin
         unique case (utc_pkg::utc_csr_type'(csr_addr))
            utc_pkg::CSR_COLUMNS:    cfg_ff.columns    <= csr_wdata;
            utc_pkg::CSR_ROWS:       cfg_ff.rows       <= csr_wdata;
            utc_pkg::CSR_FORE_COLOR: cfg_ff.fore_color <= csr_wdata[3:0];
            utc_pkg::CSR_BACK_COLOR: cfg_ff.back_color <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // result register, drains up to three words per byte
   utc_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load_i     (in_take),
      .batch_i    (batch),
      .free_o     (q_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a byte that gives words must show them in the next cycle
   a_words_follow: assert property (@(posedge clock) disable iff (reset)
      in_take && (batch.count != 2'd0) |=> rsp_tvalid)
      else $error("words of a processed byte not offered");

   // three words only come from scroll, wide draw, scroll
   a_three_words: assert property (@(posedge clock) disable iff (reset)
      in_take && (batch.count == 2'd3) |->
         (batch.cmd[0].op == utc_pkg::OP_SCROLL) && (batch.cmd[1].op == utc_pkg::OP_WIDE) &&
         (batch.cmd[2].op == utc_pkg::OP_SCROLL))
      else $error("unexpected three-word sequence");

   // a lead byte outside a sequence only opens the sequence
   a_lead_silent: assert property (@(posedge clock) disable iff (reset)
      in_take && (st_ff.pending == 2'd0) && (in_byte_ff[7:6] == 2'b11) &&
      (in_byte_ff[5:4] != 2'b11) |-> (batch.count == 2'd0) && (st_in.pending != 2'd0))
      else $error("lead byte produced output");

endmodule

>>> rtl/core/utc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_step
// utf-8 decode and cursor update for one byte, producing up to three commands
// ----------------------------------------------------------------------------
module utc_step (
   input  logic [7:0]             byte_i,
   input  utc_pkg::utc_state_type state_i,
   input  utc_pkg::utc_cfg_type   cfg_i,
   output utc_pkg::utc_state_type state_o,
   output utc_pkg::utc_batch_type batch_o
);

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TILDE = 8'd126;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [8:0] TAB_MASK   = 9'h1FC;

   always_comb begin
      logic [8:0]  ec;
      logic [8:0]  er;
      logic [8:0]  x;
      logic [8:0]  y;
      logic [1:0]  n;
      logic [15:0] code;
      logic        do_wide;
      logic        do_wrap;

      state_o = state_i;
      batch_o = '0;
      n       = 2'd0;
      x       = {1'b0, state_i.col};
      y       = {1'b0, state_i.row};
      ec      = ({1'b0, cfg_i.columns} < utc_pkg::MIN_COLUMNS) ? utc_pkg::MIN_COLUMNS
                                                              : {1'b0, cfg_i.columns};
      er      = ({1'b0, cfg_i.rows} < utc_pkg::MIN_ROWS) ? utc_pkg::MIN_ROWS
                                                        : {1'b0, cfg_i.rows};
      code    = {8'h00, byte_i};
      do_wide = 1'b0;
      do_wrap = 1'b0;

      if (state_i.pending != 2'd0) begin
         // any byte inside a sequence counts as a continuation
         code            = {state_i.partial[9:0], byte_i[5:0]};
         state_o.partial = code;
         state_o.pending = state_i.pending - 2'd1;
         do_wide         = (state_i.pending == 2'd1);
      end else if (byte_i[7] == 1'b0) begin
         do_wrap = 1'b1;
         if (byte_i == CH_LF) begin
            x = 9'd0;
            y = y + 9'd1;
         end else if (byte_i == CH_CR) begin
            x = 9'd0;
         end else if (byte_i == CH_BS) begin
            if (x != 9'd0) begin
               x = x - 9'd1;
               batch_o.cmd[n] = utc_pkg::make_cmd(utc_pkg::OP_CLEAR, 16'd0, x[7:0], y[7:0],
                                                  4'd0, cfg_i.back_color);
               n = n + 2'd1;
            end
         end else if (byte_i == CH_TAB) begin
            x = (x + 9'd4) & TAB_MASK;
            if (x >= ec) begin
               x = 9'd0;
               y = y + 9'd1;
            end
         end else if (byte_i >= CH_SPACE) begin
            batch_o.cmd[n] = utc_pkg::make_cmd(utc_pkg::OP_NARROW,
                                               {8'h00, (byte_i > CH_TILDE) ? CH_QMARK : byte_i},
                                               x[7:0], y[7:0],
                                               cfg_i.fore_color, cfg_i.back_color);
            n = n + 2'd1;
            x = x + 9'd1;
         end
      end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
         state_o.partial = {11'd0, byte_i[4:0]};
         state_o.pending = 2'd1;
      end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
         state_o.partial = {12'd0, byte_i[3:0]};
         state_o.pending = 2'd2;
      end else begin
         do_wide = 1'b1;
      end

      if (do_wide) begin
         // a wide glyph needs two free cells on the row
         if (x >= ec - 9'd1) begin
            x = 9'd0;
            y = y + 9'd1;
         end
         if (y >= er) begin
            batch_o.cmd[n] = utc_pkg::make_cmd(utc_pkg::OP_SCROLL, 16'd0, 8'd0, 8'd0,
                                               4'd0, cfg_i.back_color);
            n = n + 2'd1;
            y = er - 9'd1;
            x = 9'd0;
         end
         batch_o.cmd[n] = utc_pkg::make_cmd(utc_pkg::OP_WIDE, code, x[7:0], y[7:0],
                                            cfg_i.fore_color, cfg_i.back_color);
         n       = n + 2'd1;
         x       = x + 9'd2;
         do_wrap = 1'b1;
      end

      if (do_wrap) begin
         if (x >= ec) begin
            x = 9'd0;
            y = y + 9'd1;
         end
         if (y >= er) begin
            batch_o.cmd[n] = utc_pkg::make_cmd(utc_pkg::OP_SCROLL, 16'd0, 8'd0, 8'd0,
                                               4'd0, cfg_i.back_color);
            n = n + 2'd1;
            y = er - 9'd1;
            x = 9'd0;
         end
      end

      state_o.col   = x[7:0];
      state_o.row   = y[7:0];
      batch_o.count = n;
   end

endmodule

>>> rtl/core/utc_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_outq
// result register holding the commands of one byte and draining them in order
// ----------------------------------------------------------------------------
module utc_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_i,
   input  utc_pkg::utc_batch_type        batch_i,
   output logic                          free_o,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [1:0]                    rsp_tuser,   // op
   output logic [utc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // glyph_code, cell_col, cell_row, fg, bg
   output logic                          rsp_tlast
);

   logic [1:0]                                rem_ff;
   utc_pkg::utc_cmd_type [utc_pkg::MAX_CMDS-1:0] slot_ff;
   logic                                      pop;

   assign pop    = (rem_ff != 2'd0) && rsp_tready;
   assign free_o = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (load_i) begin
         rem_ff <= batch_i.count;
      end else if (pop) begin
         rem_ff <= rem_ff - 2'd1;
      end
   end

   // shift toward slot 0 so the head word is always at a fixed place
   always_ff @(posedge clock) begin
      if (load_i) begin
         slot_ff <= batch_i.cmd;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   assign rsp_tvalid = (rem_ff != 2'd0);
   assign rsp_tlast  = (rem_ff == 2'd1);
   assign rsp_tuser  = slot_ff[0].op;
   assign rsp_tdata  = {slot_ff[0].bg, slot_ff[0].fg, slot_ff[0].cell_row,
                        slot_ff[0].cell_col, slot_ff[0].glyph_code};

endmodule
